>>> rtl/core/arf_pkg.sv
// ============================================================================
// arf_pkg
// Shared types, codes and helpers of the AArch64 relocation fixup pipeline.
// ============================================================================
package arf_pkg;

   // ELF AArch64 relocation type numbers handled by the block.
   localparam logic [11:0] R_NONE                = 12'd0;
   localparam logic [11:0] R_ABS64               = 12'd257;
   localparam logic [11:0] R_ABS32               = 12'd258;
   localparam logic [11:0] R_ABS16               = 12'd259;
   localparam logic [11:0] R_PREL64              = 12'd260;
   localparam logic [11:0] R_PREL32              = 12'd261;
   localparam logic [11:0] R_PREL16              = 12'd262;
   localparam logic [11:0] R_LD_PREL_LO19        = 12'd273;
   localparam logic [11:0] R_ADR_PREL_LO21       = 12'd274;
   localparam logic [11:0] R_ADR_PREL_PG_HI21    = 12'd275;
   localparam logic [11:0] R_ADR_PREL_PG_HI21_NC = 12'd276;
   localparam logic [11:0] R_ADD_ABS_LO12_NC     = 12'd277;
   localparam logic [11:0] R_LDST8_ABS_LO12_NC   = 12'd278;
   localparam logic [11:0] R_TSTBR14             = 12'd279;
   localparam logic [11:0] R_CONDBR19            = 12'd280;
   localparam logic [11:0] R_JUMP26              = 12'd282;
   localparam logic [11:0] R_CALL26              = 12'd283;
   localparam logic [11:0] R_LDST16_ABS_LO12_NC  = 12'd284;
   localparam logic [11:0] R_LDST32_ABS_LO12_NC  = 12'd285;
   localparam logic [11:0] R_LDST64_ABS_LO12_NC  = 12'd286;
   localparam logic [11:0] R_LDST128_ABS_LO12_NC = 12'd299;
   localparam logic [11:0] R_ADR_GOT_PAGE        = 12'd311;
   localparam logic [11:0] R_LD64_GOT_LO12_NC    = 12'd312;
   localparam logic [11:0] R_TLSLE_ADD_HI12      = 12'd549;
   localparam logic [11:0] R_TLSLE_ADD_LO12_NC   = 12'd551;
   localparam logic [11:0] R_TLSDESC_ADR_PAGE21  = 12'd562;
   localparam logic [11:0] R_TLSDESC_LD64_LO12   = 12'd563;
   localparam logic [11:0] R_TLSDESC_ADD_LO12    = 12'd564;
   localparam logic [11:0] R_TLSDESC_CALL        = 12'd569;

   // Size of the thread control block placed ahead of the TLS area.
   localparam logic [15:0] TCB_BYTES = 16'd16;
   localparam logic [3:0]  TCB_LOG2  = 4'd4;

   // Operation classes after decode.
   typedef enum logic [4:0] {
      OP_NOP,
      OP_ABS64,
      OP_PREL64,
      OP_ABS32,
      OP_PREL32,
      OP_ABS16,
      OP_PREL16,
      OP_LD19,
      OP_ADR,
      OP_ADRP,
      OP_ADRP_NC,
      OP_LO12,
      OP_TST14,
      OP_BR26,
      OP_TLS_HI12,
      OP_TLS_LO12,
      OP_UNSUP
   } arf_op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_OVF   = 2'd1,
      ST_UNSUP = 2'd2,
      ST_PLT   = 2'd3
   } arf_status_type;

   typedef enum logic [1:0] {
      SW_NONE = 2'd0,
      SW_16   = 2'd1,
      SW_32   = 2'd2,
      SW_64   = 2'd3
   } arf_width_type;

   // Control that travels down the pipeline with each item.
   typedef struct packed {
      logic       valid;
      arf_op_type op;
      logic [2:0] lo_shift;
   } arf_ctl_type;

   // ADR/ADRP: immlo into bits 30:29, immhi into bits 23:5.
   function automatic logic [31:0] ins_adr(input logic [31:0] word,
                                           input logic [20:0] imm);
      return {word[31], imm[1:0], word[28:24], imm[20:2], word[4:0]};
   endfunction

   // Twelve-bit immediate in bits 21:10.
   function automatic logic [31:0] ins_imm12(input logic [31:0] word,
                                             input logic [11:0] imm);
      return {word[31:22], imm, word[9:0]};
   endfunction

   // Fourteen-bit branch offset in bits 18:5.
   function automatic logic [31:0] ins_imm14(input logic [31:0] word,
                                             input logic [13:0] imm);
      return {word[31:19], imm, word[4:0]};
   endfunction

   // Nineteen-bit offset in bits 23:5.
   function automatic logic [31:0] ins_imm19(input logic [31:0] word,
                                             input logic [18:0] imm);
      return {word[31:24], imm, word[4:0]};
   endfunction

   // Twenty-six-bit branch offset in bits 25:0.
   function automatic logic [31:0] ins_imm26(input logic [31:0] word,
                                             input logic [25:0] imm);
      return {word[31:26], imm};
   endfunction

endpackage

>>> rtl/core/arf_decode.sv
// ============================================================================
// arf_decode
// First stage: decodes the type number, forms S+A and the TLS block offset.
// ============================================================================
module arf_decode
   import arf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  logic [11:0] reloc_type,
   input  logic [63:0] symbol_value,
   input  logic [63:0] addend,
   input  logic [63:0] place_address,
   input  logic [31:0] old_word,
   input  logic [3:0]  tls_align_log2,
   output arf_ctl_type ctl_ff,
   output logic [63:0] sa_ff,
   output logic [63:0] place_ff,
   output logic [31:0] word_ff,
   output logic [15:0] tls_off_ff
);

   arf_ctl_type ctl_in;
   logic [15:0] tls_off_in;

   // Map the type number onto an operation class.
   always_comb begin
      ctl_in.valid    = in_valid;
      ctl_in.op       = OP_UNSUP;
      ctl_in.lo_shift = 3'd0;
      unique case (reloc_type)
         R_NONE, R_TLSDESC_CALL: ctl_in.op = OP_NOP;
         R_ABS64:                ctl_in.op = OP_ABS64;
         R_PREL64:               ctl_in.op = OP_PREL64;
         R_ABS32:                ctl_in.op = OP_ABS32;
         R_PREL32:               ctl_in.op = OP_PREL32;
         R_ABS16:                ctl_in.op = OP_ABS16;
         R_PREL16:               ctl_in.op = OP_PREL16;
         R_LD_PREL_LO19, R_CONDBR19: ctl_in.op = OP_LD19;
         R_ADR_PREL_LO21:        ctl_in.op = OP_ADR;
         R_ADR_PREL_PG_HI21, R_ADR_GOT_PAGE, R_TLSDESC_ADR_PAGE21:
            ctl_in.op = OP_ADRP;
         R_ADR_PREL_PG_HI21_NC:  ctl_in.op = OP_ADRP_NC;
         R_ADD_ABS_LO12_NC, R_LDST8_ABS_LO12_NC, R_TLSDESC_ADD_LO12: begin
            ctl_in.op       = OP_LO12;
            ctl_in.lo_shift = 3'd0;
         end
         R_LDST16_ABS_LO12_NC: begin
            ctl_in.op       = OP_LO12;
            ctl_in.lo_shift = 3'd1;
         end
         R_LDST32_ABS_LO12_NC: begin
            ctl_in.op       = OP_LO12;
            ctl_in.lo_shift = 3'd2;
         end
         R_LDST64_ABS_LO12_NC, R_LD64_GOT_LO12_NC, R_TLSDESC_LD64_LO12: begin
            ctl_in.op       = OP_LO12;
            ctl_in.lo_shift = 3'd3;
         end
         R_LDST128_ABS_LO12_NC: begin
            ctl_in.op       = OP_LO12;
            ctl_in.lo_shift = 3'd4;
         end
         R_TSTBR14:              ctl_in.op = OP_TST14;
         R_JUMP26, R_CALL26:     ctl_in.op = OP_BR26;
         R_TLSLE_ADD_HI12:       ctl_in.op = OP_TLS_HI12;
         R_TLSLE_ADD_LO12_NC:    ctl_in.op = OP_TLS_LO12;
         default:                ctl_in.op = OP_UNSUP;
      endcase
   end

   // The control block aligned up to the TLS alignment: 16 or the alignment.
   always_comb begin
      if (tls_align_log2 <= TCB_LOG2) begin
         tls_off_in = TCB_BYTES;
      end else begin
         tls_off_in = 16'd1 << tls_align_log2;
      end
   end

   // Stage registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else begin
         ctl_ff.valid <= ctl_in.valid;
      end
      ctl_ff.op       <= ctl_in.op;
      ctl_ff.lo_shift <= ctl_in.lo_shift;
      sa_ff           <= symbol_value + addend;
      place_ff        <= place_address;
      word_ff         <= old_word;
      tls_off_ff      <= tls_off_in;
   end

endmodule

>>> rtl/core/arf_arith.sv
// ============================================================================
// arf_arith
// Second stage: PC-relative, page-relative and TLS offsets from S+A.
// ============================================================================
module arf_arith
   import arf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  arf_ctl_type ctl_in_ff,
   input  logic [63:0] sa_in_ff,
   input  logic [63:0] place_in_ff,
   input  logic [31:0] word_in_ff,
   input  logic [15:0] tls_off_in_ff,
   output arf_ctl_type ctl_ff,
   output logic [63:0] sa_ff,
   output logic [63:0] prel_ff,
   output logic [63:0] page_ff,
   output logic [63:0] tls_ff,
   output logic [31:0] word_ff
);

   logic [51:0] page_hi;

   // Page difference works on the address bits above the 4 KiB offset.
   assign page_hi = sa_in_ff[63:12] - place_in_ff[63:12];

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else begin
         ctl_ff.valid <= ctl_in_ff.valid;
      end
      ctl_ff.op       <= ctl_in_ff.op;
      ctl_ff.lo_shift <= ctl_in_ff.lo_shift;
      sa_ff           <= sa_in_ff;
      prel_ff         <= sa_in_ff - place_in_ff;
      page_ff         <= {page_hi, 12'd0};
      tls_ff          <= sa_in_ff + {48'd0, tls_off_in_ff};
      word_ff         <= word_in_ff;
   end

endmodule

>>> rtl/core/arf_pack.sv
// ============================================================================
// arf_pack
// Third stage: range checks, immediate insertion and the result register.
// ============================================================================
module arf_pack
   import arf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  arf_ctl_type ctl_in_ff,
   input  logic [63:0] sa_in_ff,
   input  logic [63:0] prel_in_ff,
   input  logic [63:0] page_in_ff,
   input  logic [63:0] tls_in_ff,
   input  logic [31:0] word_in_ff,
   output logic        valid_ff,
   output logic [63:0] value_ff,
   output logic [1:0]  width_ff,
   output logic [1:0]  status_ff
);

   logic           abs32_ok;
   logic           prel32_ok;
   logic           abs16_ok;
   logic           prel16_ok;
   logic           prel20_ok;
   logic           page32_ok;
   logic           prel15_ok;
   logic           prel27_ok;
   logic           tls24_ok;
   logic [11:0]    lo12_imm;
   logic [63:0]    value_in;
   arf_width_type  width_in;
   arf_status_type status_in;

   // Signed range checks: a value fits when the bits above the limit are
   // all copies of the sign, or all zero for an unsigned upper limit.
   assign abs32_ok  = (&sa_in_ff[63:31])   || (sa_in_ff[63:32] == 32'd0);
   assign prel32_ok = (&prel_in_ff[63:31]) || (prel_in_ff[63:32] == 32'd0);
   assign abs16_ok  = (&sa_in_ff[63:15])   || (sa_in_ff[63:16] == 48'd0);
   assign prel16_ok = (&prel_in_ff[63:15]) || (prel_in_ff[63:16] == 48'd0);
   assign prel20_ok = (&prel_in_ff[63:20]) || (prel_in_ff[63:20] == 44'd0);
   assign page32_ok = (&page_in_ff[63:32]) || (page_in_ff[63:32] == 32'd0);
   assign prel15_ok = (&prel_in_ff[63:15]) || (prel_in_ff[63:15] == 49'd0);
   assign prel27_ok = (&prel_in_ff[63:27]) || (prel_in_ff[63:27] == 37'd0);
   assign tls24_ok  = (tls_in_ff[63:24] == 40'd0);

   // Low twelve bits scaled down by the access size.
   assign lo12_imm = sa_in_ff[11:0] >> ctl_in_ff.lo_shift;

   // Result selection; any error leaves value and width at zero.
   always_comb begin
      value_in  = 64'd0;
      width_in  = SW_NONE;
      status_in = ST_OK;
      unique case (ctl_in_ff.op)
         OP_NOP: begin
         end
         OP_ABS64: begin
            value_in = sa_in_ff;
            width_in = SW_64;
         end
         OP_PREL64: begin
            value_in = prel_in_ff;
            width_in = SW_64;
         end
         OP_ABS32: begin
            if (abs32_ok) begin
               value_in = {32'd0, sa_in_ff[31:0]};
               width_in = SW_32;
            end else begin
               status_in = ST_OVF;
            end
         end
         OP_PREL32: begin
            if (prel32_ok) begin
               value_in = {32'd0, prel_in_ff[31:0]};
               width_in = SW_32;
            end else begin
               status_in = ST_OVF;
            end
         end
         OP_ABS16: begin
            if (abs16_ok) begin
               value_in = {48'd0, sa_in_ff[15:0]};
               width_in = SW_16;
            end else begin
               status_in = ST_OVF;
            end
         end
         OP_PREL16: begin
            if (prel16_ok) begin
               value_in = {48'd0, prel_in_ff[15:0]};
               width_in = SW_16;
            end else begin
               status_in = ST_OVF;
            end
         end
         OP_LD19: begin
            if (prel20_ok) begin
               value_in = {32'd0, ins_imm19(word_in_ff, prel_in_ff[20:2])};
               width_in = SW_32;
            end else begin
               status_in = ST_OVF;
            end
         end
         OP_ADR: begin
            if (prel20_ok) begin
               value_in = {32'd0, ins_adr(word_in_ff, prel_in_ff[20:0])};
               width_in = SW_32;
            end else begin
               status_in = ST_OVF;
            end
         end
         OP_ADRP: begin
            if (page32_ok) begin
               value_in = {32'd0, ins_adr(word_in_ff, page_in_ff[32:12])};
               width_in = SW_32;
            end else begin
               status_in = ST_OVF;
            end
         end
         OP_ADRP_NC: begin
            value_in = {32'd0, ins_adr(word_in_ff, page_in_ff[32:12])};
            width_in = SW_32;
         end
         OP_LO12: begin
            value_in = {32'd0, ins_imm12(word_in_ff, lo12_imm)};
            width_in = SW_32;
         end
         OP_TST14: begin
            if (prel15_ok) begin
               value_in = {32'd0, ins_imm14(word_in_ff, prel_in_ff[15:2])};
               width_in = SW_32;
            end else begin
               status_in = ST_OVF;
            end
         end
         OP_BR26: begin
            if (prel27_ok) begin
               value_in = {32'd0, ins_imm26(word_in_ff, prel_in_ff[27:2])};
               width_in = SW_32;
            end else begin
               status_in = ST_PLT;
            end
         end
         OP_TLS_HI12: begin
            if (tls24_ok) begin
               value_in = {32'd0, ins_imm12(word_in_ff, tls_in_ff[23:12])};
               width_in = SW_32;
            end else begin
               status_in = ST_OVF;
            end
         end
         OP_TLS_LO12: begin
            value_in = {32'd0, ins_imm12(word_in_ff, tls_in_ff[11:0])};
            width_in = SW_32;
         end
         default: begin
            status_in = ST_UNSUP;
         end
      endcase
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= ctl_in_ff.valid;
      end
      value_ff  <= value_in;
      width_ff  <= width_in;
      status_ff <= status_in;
   end

endmodule

>>> rtl/core/arm64_relocation_fixup_top.sv
// ============================================================================
// arm64_relocation_fixup_top
// AArch64 RELA relocation fixup: one relocation entry in, one patch out.
// ============================================================================
// Usage:
//   An item is a relocation entry (type, S, A, P and the old word at P).
//   It is taken at a rising edge with start high and busy low. busy is
//   always low, so a new item may be offered in every cycle.
//   Each item gives exactly one result at the end of the pipeline:
//   rsp_valid is high for one cycle with rsp_patched_value,
//   rsp_store_width and rsp_status. Results leave in the order of entry.
//   Throughput is one item per cycle; each item passes through the
//   decode/add, offset and check/insert register stages in that order.
//   The receiver cannot stall, so results are never held back.
//   csr_we with csr_wdata writes the TLS alignment (log2); it must only be
//   changed while no item is in flight.
//   Synchronous reset empties the pipeline and sets the alignment to zero.
// ============================================================================
module arm64_relocation_fixup_top
   import arf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [11:0] req_reloc_type,
   input  logic [63:0] req_symbol_value,
   input  logic [63:0] req_addend,
   input  logic [63:0] req_place_address,
   input  logic [31:0] req_old_word,
   output logic        rsp_valid,
   output logic [63:0] rsp_patched_value,
   output logic [1:0]  rsp_store_width,
   output logic [1:0]  rsp_status,
   input  logic        csr_we,
   input  logic [3:0]  csr_wdata
);

   logic [3:0]  tls_align_log2_ff;
   arf_ctl_type s1_ctl;
   logic [63:0] s1_sa;
   logic [63:0] s1_place;
   logic [31:0] s1_word;
   logic [15:0] s1_tls_off;
   arf_ctl_type s2_ctl;
   logic [63:0] s2_sa;
   logic [63:0] s2_prel;
   logic [63:0] s2_page;
   logic [63:0] s2_tls;
   logic [31:0] s2_word;

   // The pipeline never stalls.
   assign busy = 1'b0;

   // TLS alignment register.
   always_ff @(posedge clock) begin
      if (reset) begin
         tls_align_log2_ff <= 4'd0;
      end else if (csr_we) begin
         tls_align_log2_ff <= csr_wdata;
      end
   end

   arf_decode u_decode (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (start & ~busy),
      .reloc_type     (req_reloc_type),
      .symbol_value   (req_symbol_value),
      .addend         (req_addend),
      .place_address  (req_place_address),
      .old_word       (req_old_word),
      .tls_align_log2 (tls_align_log2_ff),
      .ctl_ff         (s1_ctl),
      .sa_ff          (s1_sa),
      .place_ff       (s1_place),
      .word_ff        (s1_word),
      .tls_off_ff     (s1_tls_off)
   );

   arf_arith u_arith (
      .clock         (clock),
      .reset         (reset),
      .ctl_in_ff     (s1_ctl),
      .sa_in_ff      (s1_sa),
      .place_in_ff   (s1_place),
      .word_in_ff    (s1_word),
      .tls_off_in_ff (s1_tls_off),
      .ctl_ff        (s2_ctl),
      .sa_ff         (s2_sa),
      .prel_ff       (s2_prel),
      .page_ff       (s2_page),
      .tls_ff        (s2_tls),
      .word_ff       (s2_word)
   );

   arf_pack u_pack (
      .clock      (clock),
      .reset      (reset),
      .ctl_in_ff  (s2_ctl),
      .sa_in_ff   (s2_sa),
      .prel_in_ff (s2_prel),
      .page_in_ff (s2_page),
      .tls_in_ff  (s2_tls),
      .word_in_ff (s2_word),
      .valid_ff   (rsp_valid),
      .value_ff   (rsp_patched_value),
      .width_ff   (rsp_store_width),
      .status_ff  (rsp_status)
   );

   // A result only appears for an item that start offered at the input.
   a_rsp_follows_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, 3))
      else $error("result without a matching item");

   // Every item taken leaves the pipeline as one result.
   a_start_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##3 (rsp_valid || $past(reset, 1) || $past(reset, 2)))
      else $error("item lost in the pipeline");

   // An error status carries no store.
   a_error_no_store: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |->
         (rsp_patched_value == 64'd0 && rsp_store_width == SW_NONE))
      else $error("store reported with an error status");

   // Narrow stores keep the unused upper bits clear.
   a_narrow_clear: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_store_width == SW_16 || rsp_store_width == SW_32)) |->
         (rsp_patched_value[63:32] == 32'd0))
      else $error("narrow store with upper bits set");

endmodule
